// ===== rtl/core/lmt_pkg.sv =====
// Shared types, timing constants and helpers for the LCD mode and line timing block.
package lmt_pkg;

	localparam int unsigned CountW = 10;
	localparam int unsigned LineW  = 8;

	localparam logic [CountW-1:0] HBLANK_CLOCKS = 10'd204;
	localparam logic [CountW-1:0] OAM_CLOCKS    = 10'd80;
	localparam logic [CountW-1:0] XFER_CLOCKS   = 10'd172;
	localparam logic [CountW-1:0] LINE_CLOCKS   = HBLANK_CLOCKS + OAM_CLOCKS + XFER_CLOCKS;

	localparam logic [LineW-1:0] VISIBLE_LINES = 8'd144;
	localparam logic [LineW-1:0] TOTAL_LINES   = 8'd154;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_HBLANK_IRQ_EN = 3'd0;
	localparam logic [2:0] REG_VBLANK_IRQ_EN = 3'd1;
	localparam logic [2:0] REG_OAM_IRQ_EN    = 3'd2;
	localparam logic [2:0] REG_MATCH_IRQ_EN  = 3'd3;
	localparam logic [2:0] REG_LINE_COMPARE  = 3'd4;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef struct packed {
		logic              hblank_irq_en;
		logic              vblank_irq_en;
		logic              oam_irq_en;
		logic              match_irq_en;
		logic [LineW-1:0]  line_compare;
	} cfg_t;

	typedef struct packed {
		logic [CountW-1:0] clock_count;
		mode_t             mode;
		logic [LineW-1:0]  line;
		logic              coincidence;
	} timing_state_t;

	typedef struct packed {
		mode_t             current_mode;
		logic [LineW-1:0]  current_line;
		logic              vblank_irq;
		logic              lcd_irq;
		logic              coincidence;
		logic              line_done;
		logic [LineW-1:0]  drawn_line;
		logic              frame_done;
	} result_t;

	// Remainder by a phase length, valid while v is below sixteen times d:
	// four conditional subtractions of the shifted length.
	function automatic logic [CountW-1:0] mod_phase(input logic [CountW-1:0] v,
			input logic [CountW-1:0] d);
		logic [CountW+3:0] r;
		logic [CountW+3:0] m;
		r = {4'b0, v};
		for (int k = 3; k >= 0; k--) begin
			m = {4'b0, d} << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[CountW-1:0];
	endfunction

endpackage

// ===== rtl/core/lmt_step.sv =====
// Next-state and result logic for one elapsed-clock transaction.
module lmt_step (
	input  lmt_pkg::timing_state_t state,
	input  lmt_pkg::cfg_t          cfg,
	input  logic [7:0]             clocks,
	output lmt_pkg::timing_state_t next_state,
	output lmt_pkg::result_t       result
);
	import lmt_pkg::*;

	logic [CountW-1:0] sum;
	logic [LineW-1:0]  line_inc;
	logic              coin_new;

	assign sum      = state.clock_count + {2'b0, clocks};
	assign line_inc = state.line + 8'd1;
	assign coin_new = (state.line == cfg.line_compare);

	always_comb begin
		next_state             = state;
		next_state.clock_count = sum;
		result                 = '0;

		unique case (state.mode)
			MODE_HBLANK: begin
				if (sum >= HBLANK_CLOCKS) begin
					result.line_done       = 1'b1;
					result.drawn_line      = state.line;
					next_state.line        = line_inc;
					next_state.clock_count = mod_phase(sum, HBLANK_CLOCKS);
					if (line_inc == VISIBLE_LINES) begin
						next_state.mode   = MODE_VBLANK;
						result.vblank_irq = 1'b1;
						result.lcd_irq    = cfg.vblank_irq_en;
					end else begin
						next_state.mode = MODE_OAM;
						result.lcd_irq  = cfg.oam_irq_en;
					end
				end
			end
			MODE_VBLANK: begin
				if (sum >= LINE_CLOCKS) begin
					next_state.clock_count = mod_phase(sum, LINE_CLOCKS);
					if (line_inc == TOTAL_LINES) begin
						result.frame_done = 1'b1;
						next_state.line   = '0;
						next_state.mode   = MODE_OAM;
						result.lcd_irq    = cfg.oam_irq_en;
					end else begin
						next_state.line = line_inc;
					end
				end
			end
			MODE_OAM: begin
				if (sum >= OAM_CLOCKS) begin
					next_state.clock_count = mod_phase(sum, OAM_CLOCKS);
					next_state.mode        = MODE_XFER;
				end
			end
			MODE_XFER: begin
				if (sum >= XFER_CLOCKS) begin
					next_state.clock_count = mod_phase(sum, XFER_CLOCKS);
					next_state.mode        = MODE_HBLANK;
					result.lcd_irq         = cfg.hblank_irq_en;
					if (cfg.match_irq_en) begin
						next_state.coincidence = coin_new;
						if (coin_new) begin
							result.lcd_irq = 1'b1;
						end
					end
				end
			end
			default: begin
				next_state = state;
			end
		endcase

		result.current_mode = next_state.mode;
		result.current_line = next_state.line;
		result.coincidence  = next_state.coincidence;
	end

endmodule

// ===== rtl/core/lcd_mode_line_timing.sv =====
// Top level of the LCD mode and line timing block: channels, registers and state.
//
// Usage
//   Each input transaction on the item channel (item_valid / item_stall) carries
//   elapsed_clocks, the number of dot clocks since the previous transaction. The
//   block adds it to its line-phase counter, makes at most one mode change, and
//   returns exactly one result transaction (result_valid / result_stall) with the
//   mode, line, interrupt pulses, coincidence flag and draw/present markers.
//   Registers (interrupt enables and the line compare value) are written over the
//   cfg channel, which is always ready; write them only while the block is idle.
// Timing
//   An item is captured in an input stage, then the timing step runs as
//   combinational logic into the result register, which takes the result
//   as the item leaves the input stage. One item per cycle is sustained
//   while the receiver does not stall, with the state fed back through the step logic.
// Reset and stall
//   arst_n clears the counter, mode (horizontal blank), line, coincidence flag,
//   all registers and both valid flags. While the receiver stalls, the result
//   holds; the input stage still takes one more item, after which item_stall
//   rises until the result is taken.
module lcd_mode_line_timing (
	input  logic       clk,
	input  logic       arst_n,
	// item channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] elapsed_clocks,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] current_mode,
	output logic [7:0] current_line,
	output logic       vblank_irq,
	output logic       lcd_irq,
	output logic       coincidence,
	output logic       line_done,
	output logic [7:0] drawn_line,
	output logic       frame_done
);
	import lmt_pkg::*;

	cfg_t          cfg_q;
	timing_state_t state_q;
	timing_state_t state_next;
	result_t       step_result;
	result_t       result_q;
	logic          result_valid_q;

	logic          valid_s1;
	logic [7:0]    clocks_s1;

	logic          advance;
	logic          item_accept;

	// Move the captured item into the result register when that register is
	// empty or being drained this cycle.
	assign advance     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall  = valid_s1 && !advance;
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = 1'b1;

	// Configuration registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HBLANK_IRQ_EN: cfg_q.hblank_irq_en <= cfg_data[0];
				REG_VBLANK_IRQ_EN: cfg_q.vblank_irq_en <= cfg_data[0];
				REG_OAM_IRQ_EN:    cfg_q.oam_irq_en    <= cfg_data[0];
				REG_MATCH_IRQ_EN:  cfg_q.match_irq_en  <= cfg_data[0];
				REG_LINE_COMPARE:  cfg_q.line_compare  <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			clocks_s1 <= elapsed_clocks;
		end
	end

	lmt_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.clocks     (clocks_s1),
		.next_state (state_next),
		.result     (step_result)
	);

	// Timing state advances only as an item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{clock_count: '0, mode: MODE_HBLANK, line: '0, coincidence: 1'b0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign current_mode = result_q.current_mode;
	assign current_line = result_q.current_line;
	assign vblank_irq   = result_q.vblank_irq;
	assign lcd_irq      = result_q.lcd_irq;
	assign coincidence  = result_q.coincidence;
	assign line_done    = result_q.line_done;
	assign drawn_line   = result_q.drawn_line;
	assign frame_done   = result_q.frame_done;

	// A vertical blank pulse always comes with entry to line 144 in vertical blank.
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.vblank_irq |->
			result_q.current_mode == MODE_VBLANK && result_q.current_line == VISIBLE_LINES)
		else $error("vblank pulse outside vertical blank entry");

	// Frame completion restarts at line 0 in OAM search.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.frame_done |->
			result_q.current_line == '0 && result_q.current_mode == MODE_OAM)
		else $error("frame done without wrap to line 0");

	// A finished line is the one just left.
	a_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.line_done |->
			result_q.drawn_line + 8'd1 == result_q.current_line)
		else $error("drawn line does not precede current line");

	// The step state moves only with an item passing to the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("timing state changed without a transaction");

	// The counter stays below one full line after every step.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.clock_count < LINE_CLOCKS)
		else $error("clock counter out of range");

endmodule
